/* hw/rtl/wsds_pkg.sv */
`timescale 1ns / 1ps
package wsds_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int TAG_W   = 16;
  localparam int M1_W    = 11;
  localparam int M2_W    = 11;
  localparam int M3_W    = 9;
  localparam int WGT_W   = 16;
  localparam int SCORE_W = 17;
  localparam int RANK_W  = 6;

  // widest product is weight x 11-bit mark; three of them need two more bits
  localparam int PROD_W = WGT_W + M1_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [WGT_W-1:0] WEIGHT_FIRST_RST  = 16'd1787;
  localparam logic [WGT_W-1:0] WEIGHT_SECOND_RST = 16'd2383;
  localparam logic [WGT_W-1:0] WEIGHT_THIRD_RST  = 16'd4915;

  typedef enum logic [1:0] {
    REG_WEIGHT_FIRST  = 2'd0,
    REG_WEIGHT_SECOND = 2'd1,
    REG_WEIGHT_THIRD  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* hw/rtl/wsds_score.sv */
`timescale 1ns / 1ps
module wsds_score (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        final_i,
  input  logic [wsds_pkg::TAG_W-1:0]  tag_i,
  input  logic [wsds_pkg::M1_W-1:0]   first_mark_i,
  input  logic [wsds_pkg::M2_W-1:0]   second_mark_i,
  input  logic [wsds_pkg::M3_W-1:0]   third_mark_i,
  input  logic [wsds_pkg::WGT_W-1:0]  weight_first_i,
  input  logic [wsds_pkg::WGT_W-1:0]  weight_second_i,
  input  logic [wsds_pkg::WGT_W-1:0]  weight_third_i,
  output logic                        valid_o,
  output logic                        final_o,
  output wsds_pkg::rec_t              rec_o
);
  import wsds_pkg::*;

  logic                 v1_q, fin1_q;
  logic [TAG_W-1:0]     tag1_q;
  logic [PROD_W-1:0]    prod1_q, prod2_q, prod3_q;
  logic [PROD_W-1:0]    prod1_d, prod2_d, prod3_d;

  logic                 v2_q, fin2_q;
  rec_t                 rec2_q, rec2_d;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-9:0]     shifted;

  assign prod1_d = PROD_W'(weight_first_i) * PROD_W'(first_mark_i);
  assign prod2_d = PROD_W'(weight_second_i) * PROD_W'(second_mark_i);
  assign prod3_d = PROD_W'(weight_third_i) * PROD_W'(third_mark_i);

  assign sum     = SUM_W'(prod1_q) + SUM_W'(prod2_q) + SUM_W'(prod3_q);
  assign shifted = sum[SUM_W-1:8];

  always_comb begin
    rec2_d.tag   = tag1_q;
    rec2_d.score = (|shifted[SUM_W-9:SCORE_W]) ? SCORE_MAX : shifted[SCORE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fin1_q  <= final_i;
    tag1_q  <= tag_i;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    prod3_q <= prod3_d;
    fin2_q  <= fin1_q;
    rec2_q  <= rec2_d;
  end

  assign valid_o = v2_q;
  assign final_o = fin2_q;
  assign rec_o   = rec2_q;

endmodule

/* hw/rtl/wsds_cell.sv */
`timescale 1ns / 1ps
module wsds_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsds_pkg::cell_ctrl_t ctrl_i,
  input  wsds_pkg::rec_t       new_i,
  input  logic                 prev_keep_i,
  input  wsds_pkg::entry_t     prev_i,
  input  wsds_pkg::entry_t     next_i,
  output logic                 keep_o,
  output wsds_pkg::entry_t     ent_o
);
  import wsds_pkg::*;

  logic               valid_q, valid_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  // equal scores stay put, so earlier records keep the better rank
  assign keep_o = valid_q && (score_q >= new_i.score);

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    tag_d   = tag_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      score_d = next_i.score;
      tag_d   = next_i.tag;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        score_d = new_i.score;
        tag_d   = new_i.tag;
      end else begin
        valid_d = prev_i.valid;
        score_d = prev_i.score;
        tag_d   = prev_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    tag_q   <= tag_d;
  end

  assign ent_o.valid = valid_q;
  assign ent_o.score = score_q;
  assign ent_o.tag   = tag_q;

endmodule

/* hw/rtl/weighted_score_descending_sorter.sv */
`timescale 1ns / 1ps
// Weighted score sorter. Records enter on the s_axis channel, one item per
// cycle while tready is high; tlast marks the final record of a set. Each
// record gets score = (w1*m1 + w2*m2 + w3*m3) >> 8, saturated to 17 bits,
// through a two-stage multiply/sum pipeline, then is placed in a row of
// insertion cells that keeps the set in descending score order (ties keep
// load order). Up to 64 records are held; further ones are dropped and the
// overflow flag in m_axis_tuser is set for that set.
// The final record passes the product and score registers before it reaches
// the cells; the cells then shift the set out toward the head, one item per
// cycle on m_axis while m_axis_tready is high, with rank in tdata and tlast
// on the last one, the first item leaving in the cycle after the insert. A
// stalled receiver simply freezes the cells; nothing is lost.
// s_axis_tready stays low from acceptance of the final record until its
// last result is taken. Weights are written over the APB port at 0x0, 0x4,
// 0x8; the user must write them only while the block is idle, which the block
// itself does not enforce. Reset empties the cells, clears the count and
// overflow flag and loads the default weights.
module weighted_score_descending_sorter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] record_tag, [26:16] first_mark, [37:27] second_mark,
  // [46:38] third_mark, [47] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_tag, [32:16] out_score, [38:33] out_rank, [39] zero
  output logic [39:0] m_axis_tdata,
  // [0] overflowed
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsds_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              ovf_q, ovf_d;
  logic              busy_q, busy_d;
  logic [WGT_W-1:0]  w1_q, w2_q, w3_q;

  logic              in_fire, out_fire, cfg_wr;
  logic              ins_valid, ins_final, has_room;
  rec_t              ins_rec;
  cell_ctrl_t        ctrl;
  reg_idx_e          reg_idx;

  entry_t            ent [CAPACITY+1];
  logic              keep [CAPACITY+1];

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= WEIGHT_FIRST_RST;
      w2_q <= WEIGHT_SECOND_RST;
      w3_q <= WEIGHT_THIRD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WEIGHT_FIRST:  w1_q <= pwdata[WGT_W-1:0];
        REG_WEIGHT_SECOND: w2_q <= pwdata[WGT_W-1:0];
        REG_WEIGHT_THIRD:  w3_q <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WEIGHT_FIRST:  prdata = 32'(w1_q);
      REG_WEIGHT_SECOND: prdata = 32'(w2_q);
      REG_WEIGHT_THIRD:  prdata = 32'(w3_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------- score pipeline ----------------
  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  wsds_score u_score (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_fire),
    .final_i         (s_axis_tlast),
    .tag_i           (s_axis_tdata[15:0]),
    .first_mark_i    (s_axis_tdata[26:16]),
    .second_mark_i   (s_axis_tdata[37:27]),
    .third_mark_i    (s_axis_tdata[46:38]),
    .weight_first_i  (w1_q),
    .weight_second_i (w2_q),
    .weight_third_i  (w3_q),
    .valid_o         (ins_valid),
    .final_o         (ins_final),
    .rec_o           (ins_rec)
  );

  // ---------------- insertion cells ----------------
  assign has_room    = count_q < CNT_W'(CAPACITY);
  assign out_fire    = m_axis_tvalid && m_axis_tready;
  assign ctrl.insert = ins_valid && has_room;
  assign ctrl.shift  = out_fire;

  // head cell always sees a keeping predecessor; past the tail is empty
  assign keep[0]        = 1'b1;
  assign ent[CAPACITY]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_ent;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
    end else begin : g_body
      assign prev_ent = ent[i-1];
    end
    wsds_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (ins_rec),
      .prev_keep_i (keep[i]),
      .prev_i      (prev_ent),
      .next_i      (ent[i+1]),
      .keep_o      (keep[i+1]),
      .ent_o       (ent[i])
    );
  end

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rank_d  = rank_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    if (in_fire && s_axis_tlast) begin
      busy_d = 1'b1;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (ins_valid) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (ins_final) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          rank_d = rank_q + 1'b1;
          if (m_axis_tlast) begin
            state_d = ST_LOAD;
            count_d = '0;
            rank_d  = '0;
            ovf_d   = 1'b0;
            busy_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      rank_q  <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rank_q  <= rank_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

  assign m_axis_tvalid = (state_q == ST_DRAIN) && ent[0].valid;
  assign m_axis_tdata  = {1'b0, rank_q, ent[0].score, ent[0].tag};
  assign m_axis_tuser  = ovf_q;
  assign m_axis_tlast  = !ent[1].valid;

`ifndef NO_ASSERTIONS
  a_no_insert_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !ins_valid)
    else $error("record reached the cells while draining");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && state_q == ST_LOAD) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("overflow flagged with room left");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (!ent[0].valid && count_q == '0))
    else $error("cells not empty after last result");
`endif

endmodule

/* dv/score_sort_checker.sv */
`timescale 1ns / 1ps
module score_sort_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        run_done_i,
  output int          fail_count_o,
  output int          pending_o
);
  import wsds_pkg::*;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
    logic               overflowed;
    logic               last;
  } ranked_rec_t;

  logic [WGT_W-1:0] weight_first;
  logic [WGT_W-1:0] weight_second;
  logic [WGT_W-1:0] weight_third;
  rec_t             held_set[$];     // current set, descending score
  ranked_rec_t      sorted_out_q[$]; // results not yet seen on m_axis
  logic             set_dropped;
  logic             leftover_checked;
  int               fails;

  function automatic logic [SCORE_W-1:0] weighted_score(
    logic [M1_W-1:0] m1, logic [M2_W-1:0] m2, logic [M3_W-1:0] m3);
    logic [63:0] sum;
    sum = 64'(weight_first) * 64'(m1) + 64'(weight_second) * 64'(m2)
        + 64'(weight_third) * 64'(m3);
    sum = sum >> 8;
    return (sum > 64'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
  endfunction

  task automatic report(string msg);
    $display("%0t: sorter mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic check_result();
    ranked_rec_t got;
    ranked_rec_t want;
    got = '{tag: m_axis_tdata[15:0], score: m_axis_tdata[32:16],
            rank: m_axis_tdata[38:33], overflowed: m_axis_tuser,
            last: m_axis_tlast};
    if (sorted_out_q.size() == 0) begin
      report($sformatf("unexpected item tag %h score %0d", got.tag, got.score));
    end else begin
      want = sorted_out_q.pop_front();
      if (got.tag !== want.tag)
        report($sformatf("rank %0d tag %h, want %h", want.rank, got.tag, want.tag));
      if (got.score !== want.score)
        report($sformatf("rank %0d score %0d, want %0d", want.rank, got.score,
                         want.score));
      if (got.rank !== want.rank)
        report($sformatf("rank %0d, want %0d", got.rank, want.rank));
      if (got.overflowed !== want.overflowed)
        report($sformatf("rank %0d overflow flag %b, want %b", want.rank,
                         got.overflowed, want.overflowed));
      if (got.last !== want.last)
        report($sformatf("rank %0d tlast %b, want %b", want.rank, got.last,
                         want.last));
    end
  endtask

  task automatic take_record();
    rec_t rec;
    int   pos;
    int   n;
    rec.tag   = s_axis_tdata[15:0];
    rec.score = weighted_score(s_axis_tdata[26:16], s_axis_tdata[37:27],
                               s_axis_tdata[46:38]);
    if (held_set.size() >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      // stable: a new record goes behind every record with an equal score
      pos = 0;
      while (pos < held_set.size() && held_set[pos].score >= rec.score) pos++;
      held_set.insert(pos, rec);
    end
    if (s_axis_tlast) begin
      n = held_set.size();
      for (int k = 0; k < n; k++) begin
        sorted_out_q.push_back('{tag: held_set[k].tag, score: held_set[k].score,
                                 rank: RANK_W'(k), overflowed: set_dropped,
                                 last: (k == n - 1)});
      end
      held_set.delete();
      set_dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_first     = WEIGHT_FIRST_RST;
      weight_second    = WEIGHT_SECOND_RST;
      weight_third     = WEIGHT_THIRD_RST;
      held_set.delete();
      sorted_out_q.delete();
      set_dropped      = 1'b0;
      leftover_checked = 1'b0;
      fails            = 0;
    end else begin
      // a result never stems from a record taken at the same edge
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_WEIGHT_FIRST:  weight_first  = pwdata[WGT_W-1:0];
          REG_WEIGHT_SECOND: weight_second = pwdata[WGT_W-1:0];
          REG_WEIGHT_THIRD:  weight_third  = pwdata[WGT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_record();
      if (run_done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (sorted_out_q.size() != 0)
          report($sformatf("%0d results never arrived", sorted_out_q.size()));
      end
    end
    fail_count_o = fails;
    pending_o    = sorted_out_q.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import wsds_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 10;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic run_done = 1'b0;
  logic hold_go  = 1'b0;
  int   hold_cnt = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   cycle_cnt = 0;
  int   fail_count;
  int   pending;

  weighted_score_descending_sorter i_dut (.*);

  score_sort_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .run_done_i   (run_done),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[weighted_score_descending_sorter] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_LEN) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic push_record(logic [TAG_W-1:0] tag, logic [M1_W-1:0] m1,
                             logic [M2_W-1:0] m2, logic [M3_W-1:0] m3, logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, m3, m2, m1, tag};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic push_random_record(logic fin);
    // a quarter of the records draw from a coarse grid so scores often tie
    if ($urandom_range(0, 3) == 0)
      push_record(TAG_W'($urandom_range(0, 65535)),
                  M1_W'($urandom_range(0, 3) * 682),
                  M2_W'($urandom_range(0, 3) * 682),
                  M3_W'($urandom_range(0, 3) * 170), fin);
    else
      push_record(TAG_W'($urandom_range(0, 65535)), M1_W'($urandom_range(0, 2047)),
                  M2_W'($urandom_range(0, 2047)), M3_W'($urandom_range(0, 511)), fin);
  endtask

  task automatic push_set(int size);
    for (int i = 1; i <= size; i++) push_random_record(i == size);
  endtask

  task automatic push_random_sets(int n_items);
    int sent;
    int size;
    sent = 0;
    while (sent < n_items) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      push_set(size);
      sent += size;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // leaves psel high after the access cycle so writes can follow directly
  task automatic apb_write(reg_idx_e idx, logic [WGT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_weights(logic [WGT_W-1:0] w1, logic [WGT_W-1:0] w2,
                             logic [WGT_W-1:0] w3);
    apb_write(REG_WEIGHT_FIRST, w1);
    apb_write(REG_WEIGHT_SECOND, w2);
    apb_write(REG_WEIGHT_THIRD, w3);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    tx_idle_pct = 35;
    rx_idle_pct = 64;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default weights: field extremes, each mark alone, three-way tie
    push_record(16'h0000, 0, 0, 0, 1'b0);
    push_record(16'hFFFF, 2047, 2047, 511, 1'b0);
    push_record(16'h1234, 2047, 0, 0, 1'b0);
    push_record(16'h5678, 0, 2047, 0, 1'b0);
    push_record(16'h9ABC, 0, 0, 511, 1'b0);
    push_record(16'hAAAA, 100, 100, 100, 1'b0);
    push_record(16'h5555, 100, 100, 100, 1'b0);
    push_record(16'h0001, 100, 100, 100, 1'b1);
    // a set of one record
    push_record(16'hFFFF, 2047, 2047, 511, 1'b1);
    wait_drained();

    // full weights: scores saturate
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_record(16'h00FF, 2047, 2047, 511, 1'b0);
    push_record(16'hFF00, 1, 0, 0, 1'b0);
    push_record(16'h0F0F, 2047, 2047, 511, 1'b1);
    wait_drained();

    // zero weights: every score ties at zero, load order must hold
    set_weights(16'h0000, 16'h0000, 16'h0000);
    push_record(16'hF0F0, 2047, 2047, 511, 1'b0);
    push_record(16'h0F0F, 0, 0, 0, 1'b0);
    push_record(16'h3C3C, 1024, 512, 256, 1'b0);
    push_record(16'hC3C3, 1, 1, 1, 1'b1);
    wait_drained();

    set_weights(WGT_W'($urandom_range(0, 65535)), WGT_W'($urandom_range(0, 65535)),
                WGT_W'($urandom_range(0, 65535)));
    push_random_sets(60);
    wait_drained();

    // sender idles more than receiver; one set overflows the store,
    // its final record among the dropped ones
    tx_idle_pct = 64;
    rx_idle_pct = 35;
    set_weights(16'h0001, 16'hFFFF, 16'h0000);
    push_set(CAPACITY + 2);
    push_random_sets(30);
    wait_drained();

    // no idling; receiver holds off while two sets are offered back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_weights(WEIGHT_FIRST_RST + 16'($urandom_range(0, 255)),
                WGT_W'($urandom_range(0, 4095)), WGT_W'($urandom_range(0, 65535)));
    hold_go <= 1'b1;
    push_set(10);
    push_set(10);
    push_random_sets(40);
    wait_drained();

    run_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[weighted_score_descending_sorter] OK");
    end else begin
      $display("[weighted_score_descending_sorter] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/wsds_pkg.sv
hw/rtl/wsds_score.sv
hw/rtl/wsds_cell.sv
hw/rtl/weighted_score_descending_sorter.sv
dv/score_sort_checker.sv
dv/testbench.sv
